// ===== rtl/tle_pkg.sv =====
// Shared types, constants and pointer helpers for the console line-edit ring.
// Used by the controller, the output stage and the testbench; has no dependencies of its own.
package tle_pkg;

  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned KIND_W     = 2;

  localparam logic [CNT_W-1:0] MAX_READ = CNT_W'(64);

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SP = 8'h20;

  localparam logic [BYTE_W-1:0] BS_CODE_RESET = 8'h7F;

  localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;
    logic              accepted;
    logic [CNT_W-1:0]  read_count;
    logic              last;
  } out_item_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) r = PTR_W'(RING_DEPTH - 1);
    else r = p - PTR_W'(1);
    return r;
  endfunction

endpackage

// ===== rtl/tle_store.sv =====
// Byte store of the ring: one write port and one read port, registered read.
// Generic RAM; no package dependency.
module tle_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds between read enables, so the controller may wait on it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tle_out_stage.sv =====
// Output register for result items with valid/stall handshake.
// Depends on tle_pkg for the result item struct.
module tle_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tle_pkg::out_item_t item_i,
  output logic               free_o,
  output logic               valid_o,
  input  logic               stall_i,
  output tle_pkg::out_item_t item_o
);

  logic               valid_q, valid_d;
  tle_pkg::out_item_t item_q;

  // The slot can take a new item when empty or when its item leaves now.
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/tty_line_edit_ring_buffer.sv =====
// Console line-edit ring: takes one request at a time and returns its results.
// Insert: S_INS answers; an erase reads the store and answers from S_BS_CHK, its echo then 1 item/cycle unless stalled.
// Read: S_RD_START starts a store read; S_RD_DATA then gives one byte per cycle, limited by the read port and stalls.
// A new request is taken once the last result of the previous one is in the output register.
// Reset clears pointers and flags (ring empty) and sets the erase code to 0x7F; no clearing pass.
module tty_line_edit_ring_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  char_in_i,
  input  logic [6:0]  max_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic        accepted_o,
  output logic [6:0]  read_count_o,
  output logic        last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_BS_CHK,
    S_ECHO_SP,
    S_ECHO_BS,
    S_RD_START,
    S_RD_DATA
  } state_e;

  state_e state_q, state_d;

  logic [tle_pkg::PTR_W-1:0]  rp_q, rp_d, cp_q, cp_d, ip_q, ip_d;
  logic                       empty_q, empty_d, full_q, full_d;
  logic [tle_pkg::BYTE_W-1:0] bs_code_q, bs_code_d;
  logic [tle_pkg::BYTE_W-1:0] char_q, char_d;
  logic [tle_pkg::CNT_W-1:0]  n_q, n_d, cnt_q, cnt_d;

  logic                       mem_we, mem_re;
  logic [tle_pkg::PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [tle_pkg::BYTE_W-1:0] mem_rdata;

  logic                       out_load, out_free;
  tle_pkg::out_item_t         out_item, out_q;

  logic                       in_accept;
  logic [tle_pkg::PTR_W-1:0]  rp_inc;
  logic [tle_pkg::CNT_W-1:0]  cnt_inc;
  logic                       rd_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);

  assign rp_inc  = tle_pkg::ptr_next(rp_q);
  assign cnt_inc = cnt_q + tle_pkg::CNT_W'(1);
  // A read ends on a newline, on reaching the count, or at the commit point.
  assign rd_last = (mem_rdata == tle_pkg::CH_LF) || (cnt_inc == n_q) || (rp_inc == cp_q);

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    cp_d      = cp_q;
    ip_d      = ip_q;
    empty_d   = empty_q;
    full_d    = full_q;
    bs_code_d = bs_code_q;
    char_d    = char_q;
    n_d       = n_q;
    cnt_d     = cnt_q;
    mem_we    = 1'b0;
    mem_waddr = ip_q;
    mem_re    = 1'b0;
    mem_raddr = rp_q;
    out_load  = 1'b0;
    out_item  = '0;

    if (cfg_valid_i) begin
      bs_code_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          char_d = (char_in_i == tle_pkg::CH_CR) ? tle_pkg::CH_LF : char_in_i;
          n_d    = (max_count_i > tle_pkg::MAX_READ) ? tle_pkg::MAX_READ : max_count_i;
          cnt_d  = '0;
          state_d = (func_i == tle_pkg::FUNC_READ) ? S_RD_START : S_INS;
        end
      end

      S_INS: begin
        if (full_q) begin
          if (out_free) begin
            out_load          = 1'b1;
            out_item.kind     = tle_pkg::KIND_STATUS;
            out_item.last     = 1'b1;
            state_d           = S_IDLE;
          end
        end else if (char_q == bs_code_q) begin
          mem_re    = 1'b1;
          mem_raddr = tle_pkg::ptr_prev(ip_q);
          state_d   = S_BS_CHK;
        end else if (out_free) begin
          mem_we   = 1'b1;
          ip_d     = tle_pkg::ptr_next(ip_q);
          empty_d  = 1'b0;
          if (char_q == tle_pkg::CH_LF) begin
            cp_d = tle_pkg::ptr_next(ip_q);
          end
          if (tle_pkg::ptr_next(ip_q) == rp_q) begin
            full_d = 1'b1;
          end
          out_load           = 1'b1;
          out_item.kind      = tle_pkg::KIND_ECHO;
          out_item.data_byte = char_q;
          out_item.accepted  = 1'b1;
          out_item.last      = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_BS_CHK: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!empty_q && (mem_rdata != tle_pkg::CH_LF)) begin
            ip_d = tle_pkg::ptr_prev(ip_q);
            if (tle_pkg::ptr_prev(ip_q) == rp_q) begin
              empty_d = 1'b1;
            end
            out_item.kind      = tle_pkg::KIND_ECHO;
            out_item.data_byte = tle_pkg::CH_BS;
            state_d            = S_ECHO_SP;
          end else begin
            out_item.kind     = tle_pkg::KIND_STATUS;
            out_item.accepted = 1'b1;
            out_item.last     = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end

      S_ECHO_SP: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_item.kind      = tle_pkg::KIND_ECHO;
          out_item.data_byte = tle_pkg::CH_SP;
          state_d            = S_ECHO_BS;
        end
      end

      S_ECHO_BS: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_item.kind      = tle_pkg::KIND_ECHO;
          out_item.data_byte = tle_pkg::CH_BS;
          out_item.accepted  = 1'b1;
          out_item.last      = 1'b1;
          state_d            = S_IDLE;
        end
      end

      S_RD_START: begin
        if (!empty_q && (n_q != '0) && (rp_q != cp_q)) begin
          mem_re  = 1'b1;
          state_d = S_RD_DATA;
        end else if (out_free) begin
          // Nothing to return; a non-empty ring still re-checks its empty flag.
          if (!empty_q && (rp_q == ip_q)) begin
            empty_d = 1'b1;
          end
          out_load          = 1'b1;
          out_item.kind     = tle_pkg::KIND_STATUS;
          out_item.accepted = 1'b1;
          out_item.last     = 1'b1;
          state_d           = S_IDLE;
        end
      end

      S_RD_DATA: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_item.kind      = tle_pkg::KIND_DATA;
          out_item.data_byte = mem_rdata;
          full_d             = 1'b0;
          rp_d               = rp_inc;
          cnt_d              = cnt_inc;
          if (rd_last) begin
            if (rp_inc == ip_q) begin
              empty_d = 1'b1;
            end
            out_item.accepted   = 1'b1;
            out_item.read_count = cnt_inc;
            out_item.last       = 1'b1;
            state_d             = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = rp_inc;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rp_q      <= '0;
      cp_q      <= '0;
      ip_q      <= '0;
      empty_q   <= 1'b1;
      full_q    <= 1'b0;
      bs_code_q <= tle_pkg::BS_CODE_RESET;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      rp_q      <= rp_d;
      cp_q      <= cp_d;
      ip_q      <= ip_d;
      empty_q   <= empty_d;
      full_q    <= full_d;
      bs_code_q <= bs_code_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    n_q    <= n_d;
  end

  tle_store #(
    .DEPTH (tle_pkg::RING_DEPTH),
    .WIDTH (tle_pkg::BYTE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (char_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tle_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .item_i  (out_item),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .item_o  (out_q)
  );

  assign kind_o       = out_q.kind;
  assign data_byte_o  = out_q.data_byte;
  assign accepted_o   = out_q.accepted;
  assign read_count_o = out_q.read_count;
  assign last_o       = out_q.last;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result loaded while output register is occupied");

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_INS) && !full_q)
    else $error("store written outside a non-full insert");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_item.last) |-> (out_item.read_count <= n_q))
    else $error("read returned more bytes than requested");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_item.last) |=> (state_q == S_IDLE))
    else $error("controller not idle after final result of a request");

endmodule

// ===== verif/tty_line_edit_ring_buffer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tty_line_edit_ring_buffer: directed and random insert and
// read requests, with a behavioral copy of the line ring predicting every echo and byte.
// Depends on tle_pkg and the block's RTL only.
module tty_line_edit_ring_buffer_tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;

  logic              clk         = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [7:0]        cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              func_i      = tle_pkg::FUNC_INSERT;
  logic [7:0]        char_in_i   = '0;
  logic [6:0]        max_count_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        kind_o;
  logic [7:0]        data_byte_o;
  logic              accepted_o;
  logic [6:0]        read_count_o;
  logic              last_o;

  // Behavioral copy of the ring, updated when a request is taken.
  logic [tle_pkg::BYTE_W-1:0] line_mem [tle_pkg::RING_DEPTH];
  logic [tle_pkg::PTR_W-1:0]  rd_ptr;
  logic [tle_pkg::PTR_W-1:0]  cm_ptr;
  logic [tle_pkg::PTR_W-1:0]  wr_ptr;
  logic                       ring_empty;
  logic                       ring_full;
  logic [tle_pkg::BYTE_W-1:0] erase_code;
  tle_pkg::out_item_t         console_q [$];

  int   mismatches    = 0;
  int   cycles        = 0;
  int   sent_count    = 0;
  int   hold_requests = 0;
  int   hold_seen     = 0;
  int   hold_left     = 0;
  int   stall_left    = 0;
  logic tx_random     = 1'b0;
  logic rx_random     = 1'b0;

  tty_line_edit_ring_buffer dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_in_i    (char_in_i),
    .max_count_i  (max_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .accepted_o   (accepted_o),
    .read_count_o (read_count_o),
    .last_o       (last_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tty_line_edit_ring_buffer_tb: done, errors");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic tle_pkg::out_item_t result_item(
      input logic [tle_pkg::KIND_W-1:0] kind, input logic [tle_pkg::BYTE_W-1:0] data,
      input logic acc, input logic [tle_pkg::CNT_W-1:0] cnt, input logic last);
    tle_pkg::out_item_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.accepted   = acc;
    r.read_count = cnt;
    r.last       = last;
    return r;
  endfunction

  function automatic int fill_level();
    if (ring_full) return tle_pkg::RING_DEPTH;
    if (ring_empty) return 0;
    return int'(tle_pkg::PTR_W'(wr_ptr - rd_ptr));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == erase_code);
    return c;
  endfunction

  task automatic predict_request(input logic fn, input logic [7:0] ch, input logic [6:0] cnt);
    logic [7:0]                c;
    logic [tle_pkg::PTR_W-1:0] prev;
    logic [7:0]                taken [$];
    int                        limit;
    if (fn == tle_pkg::FUNC_INSERT) begin
      c    = (ch == tle_pkg::CH_CR) ? tle_pkg::CH_LF : ch;
      prev = wr_ptr - 1'b1;
      if (ring_full) begin
        console_q.push_back(result_item(tle_pkg::KIND_STATUS, '0, 1'b0, '0, 1'b1));
      end else if (c == erase_code) begin
        if (!ring_empty && line_mem[prev] != tle_pkg::CH_LF) begin
          wr_ptr = prev;
          if (wr_ptr == rd_ptr) ring_empty = 1'b1;
          console_q.push_back(result_item(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b0, '0, 1'b0));
          console_q.push_back(result_item(tle_pkg::KIND_ECHO, tle_pkg::CH_SP, 1'b0, '0, 1'b0));
          console_q.push_back(result_item(tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 1'b1, '0, 1'b1));
        end else begin
          console_q.push_back(result_item(tle_pkg::KIND_STATUS, '0, 1'b1, '0, 1'b1));
        end
      end else begin
        line_mem[wr_ptr] = c;
        wr_ptr     = wr_ptr + 1'b1;
        ring_empty = 1'b0;
        if (c == tle_pkg::CH_LF) cm_ptr = wr_ptr;
        if (wr_ptr == rd_ptr) ring_full = 1'b1;
        console_q.push_back(result_item(tle_pkg::KIND_ECHO, c, 1'b1, '0, 1'b1));
      end
    end else begin
      limit = (cnt > tle_pkg::MAX_READ) ? int'(tle_pkg::MAX_READ) : int'(cnt);
      // An empty ring answers at once and leaves the flags alone.
      if (!ring_empty) begin
        while (taken.size() < limit && rd_ptr != cm_ptr &&
               (taken.size() == 0 || taken[$] != tle_pkg::CH_LF)) begin
          ring_full = 1'b0;
          taken.push_back(line_mem[rd_ptr]);
          rd_ptr = rd_ptr + 1'b1;
        end
        if (rd_ptr == wr_ptr) ring_empty = 1'b1;
      end
      if (taken.size() == 0) begin
        console_q.push_back(result_item(tle_pkg::KIND_STATUS, '0, 1'b1, '0, 1'b1));
      end else begin
        foreach (taken[k]) begin
          if (k == taken.size() - 1)
            console_q.push_back(result_item(tle_pkg::KIND_DATA, taken[k], 1'b1,
                                            tle_pkg::CNT_W'(taken.size()), 1'b1));
          else
            console_q.push_back(result_item(tle_pkg::KIND_DATA, taken[k], 1'b0, '0, 1'b0));
        end
      end
    end
  endtask

  // Valid stays high after a request is taken; the next call either replaces the payload or drops
  // valid for its gap, or the caller drops valid through settle(), before the next rising edge.
  task automatic send_request(input logic fn, input logic [7:0] ch, input logic [6:0] cnt);
    int gap;
    gap = tx_random ? idle_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid_i  <= 1'b1;
    func_i      <= fn;
    char_in_i   <= ch;
    max_count_i <= cnt;
    do @(posedge clk); while (in_stall_o);
    predict_request(fn, ch, cnt);
    sent_count++;
  endtask

  task automatic insert_byte(input logic [7:0] ch);
    send_request(tle_pkg::FUNC_INSERT, ch, 7'($urandom_range(0, 127)));
  endtask

  task automatic read_bytes(input logic [6:0] cnt);
    send_request(tle_pkg::FUNC_READ, 8'($urandom_range(0, 255)), cnt);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (console_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_erase_code(input logic [7:0] code);
    settle();
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk); while (!cfg_ready_o);
    erase_code = code;
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_ring();
    read_bytes(7'd0);
    read_bytes(7'd64);
    insert_byte(erase_code);
  endtask

  task automatic test_echo_and_read();
    insert_byte("x");
    insert_byte(erase_code);
    insert_byte("a");
    insert_byte(8'h00);
    insert_byte(8'hFF);
    insert_byte(tle_pkg::CH_CR);
    // The byte before the cursor is a newline, so nothing is erased.
    insert_byte(erase_code);
    read_bytes(7'd0);
    read_bytes(7'd2);
    read_bytes(7'd127);
    insert_byte("q");
    insert_byte("r");
    read_bytes(7'd64);
    insert_byte(erase_code);
    insert_byte(erase_code);
    read_bytes(7'd63);
  endtask

  task automatic test_erase_codes();
    set_erase_code(8'h00);
    insert_byte("z");
    insert_byte(8'h00);
    set_erase_code(8'hFF);
    insert_byte("z");
    insert_byte(8'hFF);
    insert_byte(8'h7F);
    // With newline as the erase code, carriage return erases as well.
    set_erase_code(tle_pkg::CH_LF);
    insert_byte(tle_pkg::CH_CR);
    insert_byte(tle_pkg::CH_LF);
    insert_byte("m");
    insert_byte(tle_pkg::CH_LF);
    set_erase_code(tle_pkg::BS_CODE_RESET);
  endtask

  // Drains the ring, then fills it behind one short committed line and reads that line.
  task automatic test_full_ring();
    if (!ring_empty && wr_ptr != cm_ptr) insert_byte(tle_pkg::CH_LF);
    while (!ring_empty) read_bytes(7'd64);
    insert_byte("a");
    insert_byte("b");
    insert_byte("c");
    insert_byte(tle_pkg::CH_LF);
    while (!ring_full) insert_byte(plain_char());
    insert_byte(plain_char());
    insert_byte(erase_code);
    read_bytes(7'd64);
  endtask

  task automatic test_output_hold_off();
    hold_requests++;
    insert_byte("p");
    insert_byte("q");
    insert_byte(tle_pkg::CH_CR);
    read_bytes(7'd64);
    insert_byte(erase_code);
    insert_byte("w");
    insert_byte(erase_code);
  endtask

  // Text lines with erasures and stray bytes, mixed with reads. The fill level is kept
  // below the point where a full ring without a committed line would lock up.
  task automatic run_random_traffic(input int items);
    int stop_at;
    int pick;
    int len;
    stop_at = sent_count + items;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 9);
      if (fill_level() >= 56) begin
        if (cm_ptr != rd_ptr) read_bytes(7'd64);
        else insert_byte(tle_pkg::CH_LF);
      end else if (pick < 6) begin
        len = $urandom_range(1, 14);
        repeat (len) begin
          if (fill_level() < 56) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) insert_byte(erase_code);
            else if (pick < 5) insert_byte(8'($urandom_range(0, 255)));
            else insert_byte(plain_char());
          end
        end
        if ($urandom_range(0, 6) != 0)
          insert_byte($urandom_range(0, 1) ? tle_pkg::CH_CR : tle_pkg::CH_LF);
      end else if (pick < 9) begin
        if ($urandom_range(0, 9) == 0) read_bytes(7'($urandom_range(65, 127)));
        else read_bytes(7'($urandom_range(0, 64)));
      end else begin
        send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)));
      end
    end
  endtask

  // Runs right after the full-ring test, whose last read leaves the read point on the
  // commit point. Filling the rest without a newline locks the ring, so this runs last.
  task automatic test_locked_full_ring();
    while (!ring_full) insert_byte(plain_char());
    read_bytes(7'd64);
    insert_byte(plain_char());
    read_bytes(7'd10);
  endtask

  always @(negedge clk) begin : drive_output_stall
    int g;
    if (hold_requests != hold_seen) begin
      hold_seen   <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_random) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      g = idle_gap();
      out_stall_i <= (g > 0);
      if (g > 0) stall_left <= g - 1;
    end
  end

  always @(posedge clk) begin : check_results
    tle_pkg::out_item_t seen;
    tle_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.kind       = kind_o;
      seen.data_byte  = data_byte_o;
      seen.accepted   = accepted_o;
      seen.read_count = read_count_o;
      seen.last       = last_o;
      if (console_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"cycle %0d: result with nothing pending: ",
                    "kind %0d byte %02h acc %0b count %0d last %0b"},
                   cycles, seen.kind, seen.data_byte, seen.accepted, seen.read_count,
                   seen.last);
      end else begin
        want = console_q.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"cycle %0d: expected kind %0d byte %02h acc %0b count %0d last %0b, ",
                      "got kind %0d byte %02h acc %0b count %0d last %0b"},
                     cycles, want.kind, want.data_byte, want.accepted, want.read_count,
                     want.last, seen.kind, seen.data_byte, seen.accepted, seen.read_count,
                     seen.last);
        end
      end
    end
  end

  initial begin
    logic [7:0] code;
    rd_ptr     = '0;
    cm_ptr     = '0;
    wr_ptr     = '0;
    ring_empty = 1'b1;
    ring_full  = 1'b0;
    erase_code = tle_pkg::BS_CODE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni    <= 1'b1;
    tx_random = 1'b1;
    rx_random = 1'b1;

    test_empty_ring();
    test_echo_and_read();
    test_erase_codes();
    test_output_hold_off();

    set_erase_code(tle_pkg::CH_BS);
    run_random_traffic(6);
    // A stretch with no idling on either side.
    tx_random = 1'b0;
    rx_random = 1'b0;
    do code = 8'($urandom_range(0, 255)); while (code == tle_pkg::CH_LF);
    set_erase_code(code);
    run_random_traffic(6);
    tx_random = 1'b1;
    rx_random = 1'b1;
    set_erase_code(tle_pkg::BS_CODE_RESET);
    run_random_traffic(6);

    test_full_ring();
    test_locked_full_ring();
    settle();
    if (mismatches == 0)
      $display("tty_line_edit_ring_buffer_tb: done, clean");
    else
      $display("tty_line_edit_ring_buffer_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tle_pkg.sv
rtl/tle_store.sv
rtl/tle_out_stage.sv
rtl/tty_line_edit_ring_buffer.sv
verif/tty_line_edit_ring_buffer_tb.sv
